>>> hdl/rmq_pkg.sv
// Package for the rotation matrix to quaternion block.
// Holds the branch codes, used by the top level, and fixed widths. No dependencies.
package rmq_pkg;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  localparam int ELEM_W = 16;
  localparam int QMAX = 32767;
  localparam int QMIN = -32768;

endpackage

>>> hdl/rmq_if.sv
// Valid/ready channel interfaces for the matrix input and quaternion output.
// The branch field is a plain two-bit logic; no rmq_pkg dependency.
interface rmq_mat_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] m_r0c0, m_r0c1, m_r0c2;
  logic signed [15:0] m_r1c0, m_r1c1, m_r1c2;
  logic signed [15:0] m_r2c0, m_r2c1, m_r2c2;
  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface rmq_quat_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0] branch_used;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_used,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_used,
                output ready);
endinterface

>>> hdl/rmq_sqrt.sv
// Pipelined restoring integer square root, two result bits per stage.
// Stand-alone; used by the top level. Stalls with the pipeline enable.
module rmq_sqrt #(
  parameter int IN_W  = 34,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      radicand,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    root,
  output logic [TAG_W-1:0]     out_tag
);
  localparam int RW = IN_W / 2;
  localparam int NS = (RW + 1) / 2;
  // With an odd root width the first stage resolves only one bit.
  localparam int SKIP = 2 * NS - RW;

  logic [NS:0]           vld;
  logic [IN_W-1:0]       rem  [NS+1];
  logic [IN_W-1:0]       val  [NS+1];
  logic [RW-1:0]         res  [NS+1];
  logic [TAG_W-1:0]      tag  [NS+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign val[0] = radicand;
  assign res[0] = '0;
  assign tag[0] = in_tag;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [IN_W-1:0] r_c, v_c;
    logic [RW-1:0]   q_c;
    always_comb begin
      logic [IN_W+1:0] r2;
      logic [IN_W+1:0] trial;
      r_c = rem[g];
      v_c = val[g];
      q_c = res[g];
      r2 = '0;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        if (2 * g + k >= SKIP) begin
          r2 = {r_c, v_c[IN_W-1 -: 2]};
          trial = {q_c, 2'b01};
          v_c = {v_c[IN_W-3:0], 2'b00};
          if (r2 >= trial) begin
            r_c = IN_W'(r2 - trial);
            q_c = {q_c[RW-2:0], 1'b1};
          end else begin
            r_c = IN_W'(r2);
            q_c = {q_c[RW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= r_c;
        val[g+1] <= v_c;
        res[g+1] <= q_c;
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = res[NS];
  assign out_tag   = tag[NS];
endmodule

>>> hdl/rmq_div.sv
// Pipelined signed divider: truncating quotient of (d << FRAC_BITS) by 2s,
// one quotient bit per stage, saturated to 16 bits, zero if s is zero. Stand-alone.
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int D_W       = 18,
  parameter int S_W       = 17,
  parameter int TAG_W     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [D_W-1:0]   num,
  input  logic [S_W-1:0]          den,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic signed [15:0]      quot,
  output logic [TAG_W-1:0]        out_tag
);
  // Quotient magnitude below 2^(D_W-1+FRAC_BITS); 18 bits suffice to saturate.
  localparam int NW = D_W - 1 + FRAC_BITS;
  localparam int QB = 18;
  localparam int DW = S_W + 1;

  logic [QB:0]        vld;
  logic [NW-1:0]      nm  [QB+1];
  logic [DW:0]        rm  [QB+1];
  logic [QB-1:0]      qq  [QB+1];
  logic               big [QB+1];
  logic               neg [QB+1];
  logic               zr  [QB+1];
  logic [DW-1:0]      dv  [QB+1];
  logic [TAG_W-1:0]   tg  [QB+1];

  logic [D_W-1:0] mag;
  logic [NW-1:0]  nfull;
  assign mag   = num[D_W-1] ? D_W'(-num) : D_W'(num);
  assign nfull = NW'(mag) << FRAC_BITS;

  assign vld[0] = in_valid;
  // Numerator bits above the quotient window: any nonzero one means overflow
  // only if the quotient would exceed; handled by checking the high part against 2s.
  assign nm[0]  = nfull;
  assign rm[0]  = (DW+1)'(nfull >> QB);
  assign big[0] = ((DW+1)'(nfull >> QB)) >= {1'b0, den, 1'b0};
  assign qq[0]  = '0;
  assign neg[0] = num[D_W-1];
  assign zr[0]  = (den == '0);
  assign dv[0]  = {den, 1'b0};
  assign tg[0]  = in_tag;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DW:0]   r_c;
    logic [DW+1:0] sh;
    always_comb begin
      sh = {rm[g], nm[g][QB-1-g]};
      if (sh >= (DW+2)'(dv[g])) begin
        r_c = (DW+1)'(sh - (DW+2)'(dv[g]));
      end else begin
        r_c = (DW+1)'(sh);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rm[g+1]  <= r_c;
        qq[g+1]  <= {qq[g][QB-2:0], (sh >= (DW+2)'(dv[g]))};
        nm[g+1]  <= nm[g];
        big[g+1] <= big[g];
        neg[g+1] <= neg[g];
        zr[g+1]  <= zr[g];
        dv[g+1]  <= dv[g];
        tg[g+1]  <= tg[g];
      end
    end
  end

  always_comb begin
    logic ovf;
    ovf = big[QB] || (qq[QB][QB-1:15] != '0);
    if (zr[QB]) begin
      quot = '0;
    end else if (neg[QB]) begin
      quot = (ovf || qq[QB][15]) ? ((qq[QB] == (QB)'(32768) && !big[QB]) ?
             16'sh8000 : 16'sh8000) : -$signed({1'b0, qq[QB][14:0]});
    end else begin
      quot = (ovf || qq[QB][15]) ? 16'sh7fff : $signed({1'b0, qq[QB][14:0]});
    end
  end

  assign out_valid = vld[QB];
  assign out_tag   = tg[QB];
endmodule

>>> hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (trace method) in a valid/ready pipeline.
// Depends on rmq_pkg, rmq_if, rmq_sqrt and rmq_div.
// One matrix is accepted every clock cycle while the output is not stalled.
// The pipeline is a branch-select register, one square-root stage per two
// root bits (nine at the default FRAC_BITS), 18 divider stages and the
// output register; all advance together and halt only when the output
// register is full and not taken. The square root and divider set the depth.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  rmq_mat_if.sink     mat,
  rmq_quat_if.source  quat
);
  localparam int A_W   = (FRAC_BITS > 16) ? FRAC_BITS + 3 : 19;
  localparam int SQ_W  = 2 * ((A_W + FRAC_BITS + 1) / 2);
  localparam int RT_W  = SQ_W / 2;
  localparam int D_W   = 18;
  localparam int TAG_W = 2 + RT_W + 3 * D_W;

  logic en;
  assign en = !quat.valid || quat.ready;
  assign mat.ready = en;

  // Stage 1: trace, branch choice, radicand and numerators.
  logic signed [A_W-1:0] t, a_c;
  logic [1:0] br_c;
  logic signed [D_W-1:0] n0, n1, n2;
  always_comb begin
    logic signed [A_W-1:0] d0, d1, d2;
    d0 = A_W'(mat.m_r0c0);
    d1 = A_W'(mat.m_r1c1);
    d2 = A_W'(mat.m_r2c2);
    t = d0 + d1 + d2;
    if (!t[A_W-1]) begin
      br_c = rmq_pkg::BR_TRACE;
      a_c  = t;
    end else if (d1 > d0 && d2 <= d1) begin
      br_c = rmq_pkg::BR_Y;
      a_c  = d1 - d0 - d2;
    end else if (d2 > (d1 > d0 ? d1 : d0)) begin
      br_c = rmq_pkg::BR_Z;
      a_c  = d2 - d0 - d1;
    end else begin
      br_c = rmq_pkg::BR_X;
      a_c  = d0 - d1 - d2;
    end
    a_c = a_c + (A_W'(1) <<< FRAC_BITS);
    case (br_c)
      rmq_pkg::BR_TRACE: begin
        n0 = D_W'(mat.m_r2c1) - D_W'(mat.m_r1c2);
        n1 = D_W'(mat.m_r0c2) - D_W'(mat.m_r2c0);
        n2 = D_W'(mat.m_r1c0) - D_W'(mat.m_r0c1);
      end
      rmq_pkg::BR_X: begin
        n0 = D_W'(mat.m_r0c1) + D_W'(mat.m_r1c0);
        n1 = D_W'(mat.m_r2c0) + D_W'(mat.m_r0c2);
        n2 = D_W'(mat.m_r2c1) - D_W'(mat.m_r1c2);
      end
      rmq_pkg::BR_Y: begin
        n0 = D_W'(mat.m_r1c2) + D_W'(mat.m_r2c1);
        n1 = D_W'(mat.m_r0c1) + D_W'(mat.m_r1c0);
        n2 = D_W'(mat.m_r0c2) - D_W'(mat.m_r2c0);
      end
      default: begin
        n0 = D_W'(mat.m_r2c0) + D_W'(mat.m_r0c2);
        n1 = D_W'(mat.m_r1c2) + D_W'(mat.m_r2c1);
        n2 = D_W'(mat.m_r1c0) - D_W'(mat.m_r0c1);
      end
    endcase
  end

  logic                  s1_valid;
  logic [SQ_W-1:0]       s1_rad;
  logic [TAG_W-1:0]      s1_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= mat.valid;
    end
    if (en) begin
      s1_rad <= a_c[A_W-1] ? '0 : (SQ_W'(a_c) << FRAC_BITS);
      s1_tag <= {br_c, RT_W'(0), n0, n1, n2};
    end
  end

  logic              sq_valid;
  logic [RT_W-1:0]   sq_root;
  logic [TAG_W-1:0]  sq_tag;
  rmq_sqrt #(.IN_W(SQ_W), .TAG_W(TAG_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(s1_valid), .radicand(s1_rad), .in_tag(s1_tag),
    .out_valid(sq_valid), .root(sq_root), .out_tag(sq_tag)
  );

  logic [TAG_W-1:0] dv_tag_in;
  assign dv_tag_in = {sq_tag[TAG_W-1 -: 2], sq_root, sq_tag[3*D_W-1:0]};

  logic dv_valid [3];
  logic signed [15:0] dq [3];
  logic [TAG_W-1:0] dv_tag [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div #(.FRAC_BITS(FRAC_BITS), .D_W(D_W), .S_W(RT_W), .TAG_W(TAG_W)) u_div (
      .clk, .rst, .en,
      .in_valid(sq_valid),
      .num(sq_tag[(2-i)*D_W +: D_W]),
      .den(sq_root),
      .in_tag(dv_tag_in),
      .out_valid(dv_valid[i]),
      .quot(dq[i]),
      .out_tag(dv_tag[i])
    );
  end

  logic [1:0] fb;
  logic [RT_W-1:0] fs;
  logic signed [15:0] half;
  assign fb = dv_tag[0][TAG_W-1 -: 2];
  assign fs = dv_tag[0][3*D_W +: RT_W];
  assign half = ((fs >> 1) > RT_W'(32767)) ? 16'sh7fff : 16'(fs >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= dv_valid[0];
    end
    if (en) begin
      quat.branch_used <= fb;
      case (fb)
        rmq_pkg::BR_TRACE: begin
          quat.quat_w <= half;  quat.quat_x <= dq[0];
          quat.quat_y <= dq[1]; quat.quat_z <= dq[2];
        end
        rmq_pkg::BR_X: begin
          quat.quat_x <= half;  quat.quat_y <= dq[0];
          quat.quat_z <= dq[1]; quat.quat_w <= dq[2];
        end
        rmq_pkg::BR_Y: begin
          quat.quat_y <= half;  quat.quat_z <= dq[0];
          quat.quat_x <= dq[1]; quat.quat_w <= dq[2];
        end
        default: begin
          quat.quat_z <= half;  quat.quat_x <= dq[0];
          quat.quat_y <= dq[1]; quat.quat_w <= dq[2];
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ready: assert property (@(posedge clk) disable iff (rst)
    quat.valid && !quat.ready |-> !mat.ready) else $error("ready while stalled");
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] == dv_valid[1] && dv_valid[1] == dv_valid[2])
    else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    quat.valid && !quat.ready |=> $stable(quat.branch_used) && quat.valid)
    else $error("output changed under stall");
`endif
endmodule
